// File: rtl/core/wsm_pkg.sv
// Shared constants and control types for the word memory with working-set monitor.
// No dependencies; imported by every module of the block except wsm_ram.
`default_nettype none

package wsm_pkg;

    // Word address width; the word store and the page epoch store have this many address bits.
    localparam int ADDR_BITS   = 16;
    localparam int STORE_DEPTH = 1 << ADDR_BITS;

    // Page divider: quotient bits resolved per cycle and cycles per division.
    localparam int DIV_RADIX_BITS = 4;
    localparam int DIV_CYCLES     = (ADDR_BITS + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int DIV_W          = DIV_CYCLES * DIV_RADIX_BITS;
    localparam int DIV_CNT_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

    // Field and register widths.
    localparam int DATA_W   = 32;
    localparam int PAGE_W   = 17;
    localparam int WIN_W    = 16;
    localparam int WSS_W    = 17;
    localparam int EPOCH_W  = 16;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

    // Opcodes.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Register word indexes (address bit 2); PADDR_W is the byte address width.
    localparam int PADDR_W = 3;
    localparam logic REG_PAGE_WORDS    = 1'b0;
    localparam logic REG_WINDOW_LENGTH = 1'b1;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic store_acc;
        logic look;
        logic commit;
        logic clr_step;
    } t_dp_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic sweep_last;
        logic wrap;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: rtl/core/wsm_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module wsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                        i_clk,
    input  wire                        i_en,
    input  wire                        i_we,
    input  wire  [$clog2(DEPTH)-1:0]   i_addr,
    input  wire  [WIDTH-1:0]           i_wdata,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/wsm_dp.sv
// Datapath: word store, page epoch store, radix-16 page divider, window counters.
// Depends on wsm_pkg and wsm_ram.
`default_nettype none

module wsm_dp
    import wsm_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire  t_dp_cmd           i_cmd,
    output t_dp_sts                 o_sts,
    input  wire                     i_op,
    input  wire  [ADDR_BITS-1:0]    i_addr,
    input  wire  [DATA_W-1:0]       i_wdata,
    input  wire  [PAGE_W-1:0]       i_page_div,
    input  wire  [WIN_W-1:0]        i_win_lim,
    output logic [DATA_W-1:0]       o_rd_data,
    output logic                    o_closed,
    output logic [WSS_W-1:0]        o_wss
);

    // Latched access.
    logic                   r_op;
    logic [ADDR_BITS-1:0]   r_addr;
    logic [DATA_W-1:0]      r_wdata;
    logic [PAGE_W-1:0]      r_div;

    // Divider state: partial remainder and dividend that shifts into the quotient.
    logic [PAGE_W-1:0]      r_rem;
    logic [DIV_W-1:0]       r_quo;
    logic [PAGE_W-1:0]      n_rem;
    logic [DIV_W-1:0]       n_quo;

    // Window state.
    logic [WIN_W-1:0]       r_count;
    logic [WSS_W-1:0]       r_distinct;
    logic [EPOCH_W-1:0]     r_epoch;
    logic [ADDR_BITS-1:0]   r_sweep;
    logic                   r_clr_store;

    // Result registers.
    logic [DATA_W-1:0]      r_rd_data;
    logic                   r_closed;
    logic [WSS_W-1:0]       r_wss;

    // RAM ports.
    logic                   w_st_en;
    logic                   w_st_we;
    logic [ADDR_BITS-1:0]   w_st_addr;
    logic [DATA_W-1:0]      w_st_wdata;
    logic [DATA_W-1:0]      w_st_rdata;
    logic                   w_ep_en;
    logic                   w_ep_we;
    logic [ADDR_BITS-1:0]   w_ep_addr;
    logic [EPOCH_W-1:0]     w_ep_wdata;
    logic [EPOCH_W-1:0]     w_ep_rdata;

    logic [WIN_W:0]         w_next;
    logic                   w_close;
    logic                   w_hit;
    logic [WSS_W-1:0]       w_distinct_new;
    logic [ADDR_BITS-1:0]   w_page;

    // Four restoring steps per cycle.
    always_comb begin
        logic [PAGE_W:0] sh;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < DIV_RADIX_BITS; k++) begin
            sh    = {n_rem, n_quo[DIV_W-1]};
            n_quo = {n_quo[DIV_W-2:0], 1'b0};
            if (sh >= {1'b0, r_div}) begin
                n_rem    = PAGE_W'(sh - {1'b0, r_div});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = sh[PAGE_W-1:0];
            end
        end
    end

    assign w_page         = r_quo[ADDR_BITS-1:0];
    assign w_next         = {1'b0, r_count} + (WIN_W+1)'(1);
    assign w_close        = w_next >= {1'b0, i_win_lim};
    assign w_hit          = (w_ep_rdata == r_epoch);
    assign w_distinct_new = w_hit ? r_distinct : WSS_W'(r_distinct + WSS_W'(1));

    assign o_sts.sweep_last = &r_sweep;
    assign o_sts.wrap       = w_close && (r_epoch == EPOCH_MAX);

    // Word store: one access per item, zero sweep after reset.
    assign w_st_en    = i_cmd.store_acc || (i_cmd.clr_step && r_clr_store);
    assign w_st_we    = i_cmd.clr_step || (r_op == OP_WRITE);
    assign w_st_addr  = i_cmd.clr_step ? r_sweep : r_addr;
    assign w_st_wdata = i_cmd.clr_step ? '0 : r_wdata;

    // Epoch store: lookup, then mark on a miss; zero sweep retires stale epochs.
    assign w_ep_en    = i_cmd.look || i_cmd.clr_step || (i_cmd.commit && !w_hit);
    assign w_ep_we    = !i_cmd.look;
    assign w_ep_addr  = i_cmd.clr_step ? r_sweep : w_page;
    assign w_ep_wdata = i_cmd.clr_step ? '0 : r_epoch;

    wsm_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_en    (w_st_en),
        .i_we    (w_st_we),
        .i_addr  (w_st_addr),
        .i_wdata (w_st_wdata),
        .o_rdata (w_st_rdata)
    );

    wsm_ram #(.WIDTH(EPOCH_W), .DEPTH(STORE_DEPTH)) u_epoch (
        .i_clk   (i_clk),
        .i_en    (w_ep_en),
        .i_we    (w_ep_we),
        .i_addr  (w_ep_addr),
        .i_wdata (w_ep_wdata),
        .o_rdata (w_ep_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_distinct  <= '0;
            r_epoch     <= '0;
            r_sweep     <= '0;
            r_clr_store <= 1'b1;
        end else begin
            if (i_cmd.clr_step) begin
                r_sweep <= r_sweep + ADDR_BITS'(1);
                if (o_sts.sweep_last) begin
                    r_epoch     <= EPOCH_W'(1);
                    r_clr_store <= 1'b0;
                end
            end
            if (i_cmd.commit) begin
                if (w_close) begin
                    r_count    <= '0;
                    r_distinct <= '0;
                    r_epoch    <= r_epoch + EPOCH_W'(1);
                end else begin
                    r_count    <= w_next[WIN_W-1:0];
                    r_distinct <= w_distinct_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_addr  <= i_addr;
            r_wdata <= i_wdata;
            r_div   <= i_page_div;
            r_rem   <= '0;
            r_quo   <= DIV_W'(i_addr);
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
        if (i_cmd.commit) begin
            r_rd_data <= (r_op == OP_WRITE) ? '0 : w_st_rdata;
            r_closed  <= w_close;
            r_wss     <= w_close ? w_distinct_new : '0;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_closed  = r_closed;
    assign o_wss     = r_wss;

`ifndef SYNTH
    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> r_epoch != '0)
        else $error("item started with a retired epoch");
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && w_close |=> (r_distinct == '0) && (r_count == '0))
        else $error("window close did not clear the counters");
`endif

endmodule

`default_nettype wire

// File: rtl/core/wsm_ctrl.sv
// Controller: sequences accept, page division, epoch lookup, commit and clear sweeps.
// Depends on wsm_pkg.
`default_nettype none

module wsm_ctrl
    import wsm_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_valid,
    output logic         o_s_ready,
    output logic         o_m_valid,
    input  wire          i_m_ready,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_DIV   = 5'b00100,
        S_LOOK  = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [DIV_CNT_W-1:0]   r_div_cnt, n_div_cnt;
    logic                   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_div_cnt   = r_div_cnt;
        n_out_valid = r_out_valid && !i_m_ready;
        o_cmd       = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_div_cnt  = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.store_acc = (r_div_cnt == '0);
                if (r_div_cnt == DIV_LAST) begin
                    n_state = S_LOOK;
                end else begin
                    n_div_cnt = r_div_cnt + DIV_CNT_W'(1);
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                // hold until the result slot is free
                if (!r_out_valid || i_m_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = i_sts.wrap ? S_CLEAR : S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_out_valid;

`ifndef SYNTH
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result raised outside commit");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && (r_div_cnt == DIV_LAST) |=> r_state == S_LOOK)
        else $error("divider ran past its last step");
`endif

endmodule

`default_nettype wire

// File: rtl/core/word_memory_with_working_set_monitor_top.sv
// Top level of the word memory with working-set monitor: stream ports, register file.
// Depends on wsm_pkg, wsm_ctrl, wsm_dp (and wsm_ram through wsm_dp).
`default_nettype none

// Each input word is one access (read or write) to a 64K x 32 word store that
// reads as zero until written. The access's page (address / page_words, zero
// treated as one) is marked in the current working-set window; once
// window_length accesses (zero treated as one) have been seen, the result word
// reports the count of distinct pages and a fresh window starts. Exactly one
// result word leaves per input word, in order. An item passes from acceptance
// through the accept state, the page divider (4 quotient bits per cycle), one
// epoch-store lookup and a commit before the next word is accepted; the commit
// waits while an earlier result is still unread. Window membership is kept as a
// 16-bit epoch per page in a single-port RAM, so closing a window is a counter
// increment; after 65535 windows the epochs wrap and a sweep of every address
// rezeroes the epoch store. A sweep also zeroes both stores after reset.
// s_axis_tready stays low during either sweep; register writes are taken at any
// time and should only be issued while the block is idle.

module word_memory_with_working_set_monitor_top
    import wsm_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // Input words
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire  [47:0]         s_axis_tdata,   // [15:0] word_address, [47:16] write_data
    input  wire                 s_axis_tuser,   // [0] opcode
    // Result words
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    output logic [55:0]         m_axis_tdata,   // [31:0] read_data, [48:32] working_set_size
    output logic                m_axis_tuser,   // [0] window_closed
    // Register port
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [PADDR_W-1:0]  paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [PAGE_W-1:0] r_page_words;
    logic [WIN_W-1:0]  r_window_len;
    logic [PAGE_W-1:0] w_page_div;
    logic [WIN_W-1:0]  w_win_lim;
    logic              w_cfg_wr;

    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    logic [DATA_W-1:0] w_rd_data;
    logic              w_closed;
    logic [WSS_W-1:0]  w_wss;

    // Registers decode on the word index; byte lanes below it are ignored.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_words <= PAGE_W'(1);
            r_window_len <= WIN_W'(1);
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_PAGE_WORDS:    r_page_words <= pwdata[PAGE_W-1:0];
                REG_WINDOW_LENGTH: r_window_len <= pwdata[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_PAGE_WORDS:    prdata = 32'(r_page_words);
            REG_WINDOW_LENGTH: prdata = 32'(r_window_len);
            default:           prdata = '0;
        endcase
    end

    // Zero page size and zero window length both behave as one.
    assign w_page_div = (r_page_words == '0) ? PAGE_W'(1) : r_page_words;
    assign w_win_lim  = (r_window_len == '0) ? WIN_W'(1) : r_window_len;

    wsm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (w_cmd),
        .i_sts     (w_sts)
    );

    // Addresses wrap to the store's address width.
    wsm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_op       (s_axis_tuser),
        .i_addr     (s_axis_tdata[ADDR_BITS-1:0]),
        .i_wdata    (s_axis_tdata[47:16]),
        .i_page_div (w_page_div),
        .i_win_lim  (w_win_lim),
        .o_rd_data  (w_rd_data),
        .o_closed   (w_closed),
        .o_wss      (w_wss)
    );

    assign m_axis_tdata = {7'b0, w_wss, w_rd_data};
    assign m_axis_tuser = w_closed;

endmodule

`default_nettype wire

// File: tb/sv/wsm_access_checker.sv
// Result checker for the word memory with working-set monitor: watches the input,
// result and register channels, predicts every result word and compares it.
// Depends on wsm_pkg for widths, opcodes and register indexes.

module wsm_access_checker
    import wsm_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_tvalid,
    input  wire                 i_in_tready,
    input  wire  [47:0]         i_in_tdata,    // [15:0] word_address, [47:16] write_data
    input  wire                 i_in_tuser,    // [0] opcode
    input  wire                 i_out_tvalid,
    input  wire                 i_out_tready,
    input  wire  [55:0]         i_out_tdata,   // [31:0] read_data, [48:32] working_set_size
    input  wire                 i_out_tuser,   // [0] window_closed
    input  wire                 i_psel,
    input  wire                 i_penable,
    input  wire                 i_pwrite,
    input  wire  [PADDR_W-1:0]  i_paddr,
    input  wire  [31:0]         i_pwdata,
    input  wire                 i_pready,
    output int                  o_pending,
    output int                  o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              window_closed;
        logic [WSS_W-1:0]  set_size;
    } t_access_result;

    logic [DATA_W-1:0] word_copy [STORE_DEPTH];
    bit                touched_pages [int];
    logic [PAGE_W-1:0] cfg_page_words;
    logic [WIN_W-1:0]  cfg_window_len;
    logic [WIN_W-1:0]  refs_in_window;
    t_access_result    awaited_results [$];
    int                errors = 0;
    int                result_index = 0;

    task automatic flag_error(input string msg);
        $display("ERROR at %0t ns, result %0d: %s", $time, result_index, msg);
        errors++;
    endtask

    // Apply one access to the shadow state and return the result word it owes.
    function automatic t_access_result perform_access(input logic op,
                                                      input logic [15:0] addr_in,
                                                      input logic [DATA_W-1:0] data);
        t_access_result        res;
        logic [ADDR_BITS-1:0]  addr;
        int unsigned           divisor;
        int unsigned           limit;
        int unsigned           page;
        int unsigned           next_count;
        res        = '0;
        addr       = ADDR_BITS'(addr_in);
        divisor    = (cfg_page_words == '0) ? 1 : cfg_page_words;
        limit      = (cfg_window_len == '0) ? 1 : cfg_window_len;
        page       = addr / divisor;
        touched_pages[int'(page)] = 1'b1;
        if (op == OP_WRITE)
            word_copy[addr] = data;
        else
            res.read_data = word_copy[addr];
        next_count = refs_in_window + 1;
        if (next_count >= limit) begin
            res.window_closed = 1'b1;
            res.set_size      = WSS_W'(touched_pages.num());
            touched_pages.delete();
            refs_in_window    = '0;
        end else begin
            refs_in_window = WIN_W'(next_count);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_access_result want;
        if (!i_rst_n) begin
            foreach (word_copy[i]) word_copy[i] = '0;
            touched_pages.delete();
            awaited_results.delete();
            cfg_page_words = PAGE_W'(1);
            cfg_window_len = WIN_W'(1);
            refs_in_window = '0;
        end else begin
            // Retire first: a result never belongs to a word taken at the same edge.
            if (i_out_tvalid && i_out_tready) begin
                if (awaited_results.size() == 0) begin
                    flag_error($sformatf("result word with nothing awaited, tdata %h tuser %b",
                                         i_out_tdata, i_out_tuser));
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out_tdata[31:0] !== want.read_data)
                        flag_error($sformatf("read_data %h, expected %h",
                                             i_out_tdata[31:0], want.read_data));
                    if (i_out_tuser !== want.window_closed)
                        flag_error($sformatf("window_closed %b, expected %b",
                                             i_out_tuser, want.window_closed));
                    if (i_out_tdata[48:32] !== want.set_size)
                        flag_error($sformatf("working_set_size %0d, expected %0d",
                                             i_out_tdata[48:32], want.set_size));
                    if (i_out_tdata[55:49] !== 7'd0)
                        flag_error($sformatf("tdata padding %h, expected zero",
                                             i_out_tdata[55:49]));
                end
                result_index++;
            end
            if (i_in_tvalid && i_in_tready)
                awaited_results.push_back(perform_access(i_in_tuser, i_in_tdata[15:0],
                                                         i_in_tdata[47:16]));
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[PADDR_W-1:2])
                    REG_PAGE_WORDS:    cfg_page_words = i_pwdata[PAGE_W-1:0];
                    REG_WINDOW_LENGTH: cfg_window_len = i_pwdata[WIN_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= errors;
    end

endmodule

// File: tb/sv/word_memory_with_working_set_monitor_top_tb.sv
// Top of the testbench for the word memory with working-set monitor: clock, reset,
// register writes, access stimulus, result back-pressure and the verdict.
// Depends on wsm_pkg, wsm_access_checker and the block's top level.

module word_memory_with_working_set_monitor_top_tb
    import wsm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // The block clears both stores after reset, then takes the words one by
    // one; the limit covers the whole run with room to spare.
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int RESET_CYCLES = 3;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    wire                s_axis_tready;
    logic [47:0]        s_axis_tdata  = '0;    // [15:0] word_address, [47:16] write_data
    logic               s_axis_tuser  = 1'b0;  // [0] opcode
    wire                m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    wire  [55:0]        m_axis_tdata;          // [31:0] read_data, [48:32] working_set_size
    wire                m_axis_tuser;          // [0] window_closed
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [PADDR_W-1:0] paddr         = '0;
    logic [31:0]        pwdata        = '0;
    wire  [31:0]        prdata;
    wire                pready;

    int pending_results;
    int fail_count;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_token     = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    word_memory_with_working_set_monitor_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    wsm_access_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .i_out_tuser  (m_axis_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_pending    (pending_results),
        .o_fail_count (fail_count)
    );

    // Watchdog: end the run as failed once the cycle counter reaches CYCLE_LIMIT.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side. A new hold token starts a long hold-off, counted here;
    // otherwise stall at random with the current phase's rate.
    always @(posedge i_clk) begin
        if (hold_token != hold_seen) begin
            hold_seen     <= hold_token;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one access word, after a random gap, and hold it until taken.
    // Called right after a rising edge; returns right after the accepting edge.
    task automatic send_word(input logic op, input logic [15:0] addr,
                             input logic [31:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {data, addr};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Setup cycle, then access cycle; psel stays up so writes can run back to back.
    task automatic write_register(input logic reg_index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({reg_index, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // Stop offering, let every awaited result drain, then program both registers.
    task automatic apply_config(input logic [PAGE_W-1:0] page_words,
                                input logic [WIN_W-1:0] window_length);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        write_register(REG_PAGE_WORDS, 32'(page_words));
        write_register(REG_WINDOW_LENGTH, 32'(window_length));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One random phase: a configuration, idle rates and a run of accesses.
    // Half of the accesses hit a small hot region so reads find written words and
    // pages repeat inside a window; the rest roam the whole address space.
    task automatic run_phase(input logic [PAGE_W-1:0] page_words,
                             input logic [WIN_W-1:0] window_length,
                             input int idle_pct, input int stall_pct,
                             input int word_count, input bit long_hold);
        logic        op;
        logic [15:0] addr;
        logic [31:0] data;
        logic [15:0] hot_base;
        apply_config(page_words, window_length);
        send_idle_pct  = idle_pct;
        recv_stall_pct <= stall_pct;
        hot_base       = 16'($urandom);
        // Hold the result side off while the sender keeps offering, so the
        // block backs up and drops its input ready.
        if (long_hold)
            hold_token <= hold_token + 1;
        repeat (word_count) begin
            op = 1'($urandom_range(1));
            case ($urandom_range(9))
                0, 1, 2, 3, 4: addr = hot_base + 16'($urandom_range(63));
                5, 6, 7:       addr = 16'($urandom);
                8:             addr = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                default:       addr = {4'($urandom), 12'h000};
            endcase
            case ($urandom_range(9))
                0:       data = 32'h8000_0000;
                1:       data = 32'h7FFF_FFFF;
                2:       data = 32'h0000_0000;
                default: data = $urandom;
            endcase
            send_word(op, addr, data);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: one-word pages, every access closes a window.
        // Extremes of address and data; a read of a never-written word returns
        // zero; a write returns zero read data; write data on a read is ignored.
        send_word(OP_WRITE, 16'h0000, 32'h7FFF_FFFF);
        send_word(OP_WRITE, 16'hFFFF, 32'h8000_0000);
        send_word(OP_READ,  16'h0000, 32'hFFFF_FFFF);
        send_word(OP_READ,  16'hFFFF, 32'h0000_0000);
        send_word(OP_READ,  16'h1234, 32'h5A5A_A5A5);
        send_word(OP_WRITE, 16'h00FF, 32'hFFFF_FFFF);
        send_word(OP_READ,  16'h00FF, 32'h0000_0000);

        // Zero page size and zero window length both behave as one.
        apply_config('0, '0);
        send_word(OP_WRITE, 16'h8000, 32'h0000_0001);
        send_word(OP_READ,  16'h8000, 32'hCAFE_F00D);

        // 16-word pages, 4-access windows: pages 0, 0, 1, 4095 give a set of 3,
        // and the open accesses report a set size of zero.
        apply_config(PAGE_W'(16), WIN_W'(4));
        send_word(OP_READ,  16'h0000, 32'h0000_0000);
        send_word(OP_WRITE, 16'h000F, 32'h1234_5678);
        send_word(OP_READ,  16'h0010, 32'h0000_0000);
        send_word(OP_READ,  16'hFFFF, 32'h0000_0000);
        send_word(OP_READ,  16'h000F, 32'h0000_0000);

        // Largest page: the whole space is one page.
        apply_config(PAGE_W'(17'h10000), WIN_W'(3));
        send_word(OP_READ,  16'h0000, 32'h0000_0000);
        send_word(OP_WRITE, 16'h7FFF, 32'h8000_0001);
        send_word(OP_READ,  16'hFFFF, 32'h0000_0000);

        // All-ones register values.
        apply_config(PAGE_W'(17'h1FFFF), WIN_W'(16'hFFFF));
        send_word(OP_READ,  16'h7FFF, 32'h0000_0000);
        send_word(OP_WRITE, 16'hAAAA, 32'h5555_5555);

        // Random phases: no idling, sender idle, receiver stalling, both; then mixes.
        run_phase(PAGE_W'(1),         WIN_W'(5),       0,  0,  50, 1'b0);
        run_phase(PAGE_W'(64),        WIN_W'(16),      75, 0,  50, 1'b0);
        run_phase(PAGE_W'(17'h10000), WIN_W'(7),       0,  75, 50, 1'b0);
        run_phase(PAGE_W'(256),       WIN_W'(32),      36, 36, 50, 1'b0);
        run_phase('0,                 '0,              36, 36, 30, 1'b0);
        run_phase(PAGE_W'(1000),      WIN_W'(9),       0,  36, 60, 1'b1);
        run_phase(PAGE_W'($urandom_range(17'h1FFFF)), WIN_W'($urandom_range(24, 1)),
                  36, 36, 50, 1'b0);
        run_phase(PAGE_W'(3),         WIN_W'(16'hFFFF), 0, 0,  40, 1'b0);
        run_phase(PAGE_W'($urandom_range(4096, 1)), WIN_W'($urandom_range(40)),
                  75, 75, 50, 1'b0);

        // Drain: wait for every awaited result, then keep clocking to catch strays.
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
